>>> src/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the websocket frame deframer.
// Used by wsd_front, wsd_queue, wsd_back and websocket_frame_deframer.
package wsd_pkg;

   localparam int WSD_QUEUE_DEPTH = 2;

   localparam logic [3:0] OPC_TEXT  = 4'h1;
   localparam logic [3:0] OPC_CLOSE = 4'h8;
   localparam logic [3:0] OPC_PING  = 4'h9;
   localparam logic [3:0] OPC_PONG  = 4'hA;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_TEXT  = 2'd1;
   localparam logic [1:0] ACT_PONG  = 2'd2;
   localparam logic [1:0] ACT_CLOSE = 2'd3;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] CNT_EXT16 = 4'd2;
   localparam logic [3:0] CNT_EXT64 = 4'd8;
   localparam logic [3:0] CNT_KEY   = 4'd4;

   typedef enum logic [2:0] {
      ST_HDR0,
      ST_HDR1,
      ST_EXT,
      ST_KEY,
      ST_DATA
   } wsd_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic       byte_valid;
      logic       frame_end;
      logic [3:0] opcode;
      logic       fin;
      logic [1:0] action;
   } wsd_word_type;

   function automatic logic opcode_supported(input logic [3:0] op);
      return (op == OPC_TEXT) || (op == OPC_CLOSE) || (op == OPC_PING) || (op == OPC_PONG);
   endfunction

   function automatic logic [1:0] end_action(input logic [3:0] op, input logic nonempty);
      logic [1:0] act;
      act = ACT_NONE;
      if (op == OPC_CLOSE) begin
         act = ACT_CLOSE;
      end else if (op == OPC_PING) begin
         act = ACT_PONG;
      end else if (op == OPC_TEXT && nonempty) begin
         act = ACT_TEXT;
      end
      return act;
   endfunction

endpackage

>>> src/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// Websocket frame deframer, top level: header parser, word queue, output stage.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
//
// Usage:
//   req_ channel carries one received stream byte per word (req_rx_byte).
//   rsp_ channel carries one result word per payload byte, plus one word with
//   frame_end for a frame that ends in its header (empty payload or unknown
//   opcode). Header, length and key bytes give no word otherwise.
//   A result word goes through the queue and then the output register to rsp_.
//   Throughput: one byte per cycle while req_ready is high; the output stage
//   drains one queue entry per cycle while its register is empty or rsp_ready is high.
//   Stall: while rsp_ready is low the output register holds its word and the
//   queue fills; req_ready drops only when the queue is full.
//   Reset: parser returns to the first header byte, queue and output empty.
//   After a close frame or an unknown opcode, bytes are still taken but
//   dropped until reset.
module websocket_frame_deframer #(
   parameter int QueueDepth = wsd_pkg::WSD_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_frame_end,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_final_fragment,
   output logic [1:0] rsp_action
);
   import wsd_pkg::*;

   logic         q_full;
   logic         push;
   wsd_word_type push_word;
   logic         pop;
   logic         head_valid;
   wsd_word_type head_word;

   assign req_ready = !q_full;

   wsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (req_valid && req_ready),
      .rx_byte   (req_rx_byte),
      .push      (push),
      .push_word (push_word)
   );

   wsd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   wsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_word          (head_word),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_action         (rsp_action)
   );

endmodule

>>> src/wsd_front.sv
`timescale 1ns / 1ps
// Header parser: takes one byte a cycle while take is high, tracks the frame and pushes result words.
// Depends on wsd_pkg.
module wsd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            rx_byte,
   output logic                  push,
   output wsd_pkg::wsd_word_type push_word
);
   import wsd_pkg::*;

   wsd_state_type state_ff, state_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic          fin_ff, fin_in;
   logic [3:0]    op_ff, op_in;
   logic          masked_ff, masked_in;
   logic [31:0]   key_ff, key_in;
   logic [63:0]   len_ff, len_in;
   logic [1:0]    idx_ff, idx_in;
   logic          stop_ff, stop_in;

   logic        act;
   logic        hdr_done;
   logic        hdr_zero;
   logic        data_end;
   logic [63:0] len_shift;
   logic [3:0]  cnt_dec;
   logic [6:0]  len7;

   assign act       = take && !stop_ff;
   assign len_shift = {len_ff[55:0], rx_byte};
   assign cnt_dec   = cnt_ff - 4'd1;
   assign len7      = rx_byte[6:0];

   always_comb begin
      hdr_done = 1'b0;
      hdr_zero = 1'b0;
      data_end = 1'b0;
      if (act) begin
         case (state_ff)
            ST_HDR1: begin
               if (len7 != LEN_EXT16 && len7 != LEN_EXT64 && !rx_byte[7]) begin
                  hdr_done = 1'b1;
                  hdr_zero = (len7 == 7'd0);
               end
            end
            ST_EXT: begin
               if (cnt_dec == 4'd0 && !masked_ff) begin
                  hdr_done = 1'b1;
                  hdr_zero = (len_shift == 64'd0);
               end
            end
            ST_KEY: begin
               if (cnt_dec == 4'd0) begin
                  hdr_done = 1'b1;
                  hdr_zero = (len_ff == 64'd0);
               end
            end
            ST_DATA: begin
               data_end = (len_ff == 64'd1);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      if (act) begin
         case (state_ff)
            ST_HDR1: begin
               if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                  state_in = ST_EXT;
               end else if (rx_byte[7]) begin
                  state_in = ST_KEY;
               end else begin
                  state_in = ST_HDR0;
               end
            end
            ST_EXT: begin
               if (cnt_dec == 4'd0) begin
                  state_in = masked_ff ? ST_KEY : ST_HDR0;
               end
            end
            ST_KEY: begin
               if (cnt_dec == 4'd0) begin
                  state_in = ST_HDR0;
               end
            end
            ST_DATA: begin
               if (data_end) begin
                  state_in = ST_HDR0;
               end
            end
            default: begin
               state_in = ST_HDR1;
            end
         endcase
         if (hdr_done && !hdr_zero && opcode_supported(op_ff)) begin
            state_in = ST_DATA;
         end
      end
   end

   always_comb begin
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      op_in     = op_ff;
      masked_in = masked_ff;
      key_in    = key_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      stop_in   = stop_ff;
      if (act) begin
         case (state_ff)
            ST_HDR1: begin
               masked_in = rx_byte[7];
               if (len7 == LEN_EXT16) begin
                  cnt_in = CNT_EXT16;
                  len_in = 64'd0;
               end else if (len7 == LEN_EXT64) begin
                  cnt_in = CNT_EXT64;
                  len_in = 64'd0;
               end else begin
                  len_in = {57'd0, len7};
                  if (rx_byte[7]) begin
                     cnt_in = CNT_KEY;
                  end
               end
            end
            ST_EXT: begin
               len_in = len_shift;
               cnt_in = cnt_dec;
               if (cnt_dec == 4'd0 && masked_ff) begin
                  cnt_in = CNT_KEY;
               end
            end
            ST_KEY: begin
               key_in = {key_ff[23:0], rx_byte};
               cnt_in = cnt_dec;
            end
            ST_DATA: begin
               len_in = len_ff - 64'd1;
               idx_in = idx_ff + 2'd1;
               if (data_end) begin
                  idx_in = 2'd0;
                  if (op_ff == OPC_CLOSE) begin
                     stop_in = 1'b1;
                  end
               end
            end
            default: begin
               fin_in = rx_byte[7];
               op_in  = rx_byte[3:0];
            end
         endcase
         if (hdr_done) begin
            cnt_in = 4'd0;
            idx_in = 2'd0;
            if (!opcode_supported(op_ff) || (hdr_zero && op_ff == OPC_CLOSE)) begin
               stop_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      push                 = 1'b0;
      push_word.data       = 8'd0;
      push_word.key        = 8'd0;
      push_word.byte_valid = 1'b0;
      push_word.frame_end  = 1'b0;
      push_word.opcode     = op_ff;
      push_word.fin        = fin_ff;
      push_word.action     = ACT_NONE;
      if (act && state_ff == ST_DATA) begin
         push                 = 1'b1;
         push_word.data       = rx_byte;
         push_word.byte_valid = 1'b1;
         push_word.frame_end  = data_end;
         if (masked_ff) begin
            case (idx_ff)
               2'd0:    push_word.key = key_ff[31:24];
               2'd1:    push_word.key = key_ff[23:16];
               2'd2:    push_word.key = key_ff[15:8];
               default: push_word.key = key_ff[7:0];
            endcase
         end
         if (data_end) begin
            push_word.action = end_action(op_ff, 1'b1);
         end
      end else if (hdr_done) begin
         if (!opcode_supported(op_ff)) begin
            push                = 1'b1;
            push_word.frame_end = 1'b1;
            push_word.action    = ACT_CLOSE;
         end else if (hdr_zero) begin
            push                = 1'b1;
            push_word.frame_end = 1'b1;
            push_word.action    = end_action(op_ff, 1'b0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HDR0;
         cnt_ff    <= 4'd0;
         fin_ff    <= 1'b0;
         op_ff     <= 4'd0;
         masked_ff <= 1'b0;
         key_ff    <= 32'd0;
         len_ff    <= 64'd0;
         idx_ff    <= 2'd0;
         stop_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
         op_ff     <= op_in;
         masked_ff <= masked_in;
         key_ff    <= key_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         stop_ff   <= stop_in;
      end
   end

endmodule

>>> src/wsd_queue.sv
`timescale 1ns / 1ps
// Short word queue between the header parser and the output stage.
// Depends on wsd_pkg.
module wsd_queue #(
   parameter int Depth = wsd_pkg::WSD_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wsd_pkg::wsd_word_type push_word,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output wsd_pkg::wsd_word_type head_word
);
   import wsd_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   wsd_word_type          mem [Depth];
   logic [PtrWidth-1:0]   wr_ff, wr_in;
   logic [PtrWidth-1:0]   rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (cnt_ff == CntFull);
   assign head_valid = (cnt_ff != '0);
   assign head_word  = mem[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrLast) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrLast) ? '0 : rd_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> src/wsd_back.sv
`timescale 1ns / 1ps
// Output stage: unmasks the payload byte and holds the result word for the receiver.
// Depends on wsd_pkg.
module wsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  wsd_pkg::wsd_word_type head_word,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_payload_byte,
   output logic                  rsp_byte_valid,
   output logic                  rsp_frame_end,
   output logic [3:0]            rsp_frame_opcode,
   output logic                  rsp_final_fragment,
   output logic [1:0]            rsp_action
);
   import wsd_pkg::*;

   logic         valid_ff, valid_in;
   wsd_word_type out_ff, out_in;

   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      if (pop) begin
         valid_in    = 1'b1;
         out_in      = head_word;
         out_in.data = head_word.data ^ head_word.key;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_payload_byte   = out_ff.data;
   assign rsp_byte_valid     = out_ff.byte_valid;
   assign rsp_frame_end      = out_ff.frame_end;
   assign rsp_frame_opcode   = out_ff.opcode;
   assign rsp_final_fragment = out_ff.fin;
   assign rsp_action         = out_ff.action;

endmodule
